[rtl/core/oei_pkg.sv]
// Shared types, constants and saturation helper for the ODE explicit integrator.
// Used by oei_mul, oei_div and ode_explicit_integrator. No dependencies.
`default_nettype none

package oei_pkg;

    localparam int VALUE_W    = 32;
    localparam int FRAC_W     = 24;
    localparam int H_W        = 31;
    localparam int CNT_W      = 11;
    localparam int MAX_STEPS  = 1024;
    localparam int ACC_W      = 36;
    localparam int MAG_W      = 35;
    localparam int WIDE_W     = 2 * VALUE_W + 2 - FRAC_W;
    localparam int METH_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // Division by six as a multiply by ceil(2^36 / 6), split into two partial products.
    localparam int DIV_LO_W   = 18;
    localparam int DIV_HI_W   = MAG_W - DIV_LO_W;
    localparam int RCP6_W     = 34;
    localparam int RCP6_SH    = 36;
    localparam int PLO_W      = DIV_LO_W + RCP6_W;
    localparam int PHI_W      = DIV_HI_W + RCP6_W;
    localparam int PSUM_W     = MAG_W + RCP6_W;
    localparam logic [RCP6_W-1:0] RCP6 = 34'd11453246123;

    localparam logic [METH_W-1:0] METH_EULER = 3'd0;
    localparam logic [METH_W-1:0] METH_HEUN  = 3'd1;
    localparam logic [METH_W-1:0] METH_MID   = 3'd2;
    localparam logic [METH_W-1:0] METH_RK3   = 3'd3;
    localparam logic [METH_W-1:0] METH_RK4   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_METHOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd1;

    localparam logic [METH_W-1:0] METHOD_RST = METH_RK4;
    localparam logic [H_W-1:0]    STEP_RST   = 31'd8388608;

    typedef logic signed [VALUE_W-1:0] val_t;

    typedef struct packed {
        val_t val;
        logic ovf;
    } sat_t;

    // Clamp a wide signed value to the value range and report clipping.
    function automatic sat_t sat_wide(input logic signed [WIDE_W-1:0] v);
        sat_t r;
        logic signed [WIDE_W-1:0] vmax;
        logic signed [WIDE_W-1:0] vmin;
        vmax = {{(WIDE_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
        vmin = ~vmax;
        if (v > vmax) begin
            r.val = vmax[VALUE_W-1:0];
            r.ovf = 1'b1;
        end else if (v < vmin) begin
            r.val = vmin[VALUE_W-1:0];
            r.ovf = 1'b1;
        end else begin
            r.val = v[VALUE_W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ode_explicit_integrator.sv]
// Top level: sequencer for Euler, Heun, midpoint, RK3 and RK4 steps of dy/dt = -t*y.
// Depends on oei_pkg, oei_mul and oei_div.
//
//   channel | signals                                  | direction
//   cfg     | cfg_write, cfg_index, cfg_data           | in, write only
//   in      | in_valid/in_ready, y_start, t_start,     | in
//           | step_count                               |
//   out     | out_valid/out_ready, y_final, t_final,   | out
//           | saturated                                |
//
// A new item is accepted only after the last one has left the sequencer. The time per
// step depends on the method; the shared multiplier and, for Heun, RK3 and RK4, the
// divide for the weighted average set it. A zero-step item goes from idle straight to
// the finish state. in_ready is high only while the sequencer is idle.
// A finished word sits in the output register until taken; the sequencer waits only
// if that register is full. Reset is asynchronous and selects RK4 with step 0.5.
`default_nettype none

module ode_explicit_integrator (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [oei_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [oei_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire oei_pkg::val_t                         y_start,
    input  wire oei_pkg::val_t                         t_start,
    input  wire logic [oei_pkg::CNT_W-1:0]             step_count,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output oei_pkg::val_t                              y_final,
    output oei_pkg::val_t                              t_final,
    output logic                                       saturated
);

    typedef enum logic [3:0] {
        S_IDLE, S_KMUL, S_KWR, S_AMUL, S_AACC, S_YARG,
        S_AVG, S_DVGO, S_DIV, S_UMUL, S_UWR, S_FIN
    } state_t;

    typedef enum logic [1:0] {W_ADD, W_SUB, W_DBL} wt_t;

    state_t                           state_reg;
    logic [oei_pkg::METH_W-1:0]       method_reg;
    logic [oei_pkg::H_W-1:0]          step_reg;
    oei_pkg::val_t                    y_reg;
    oei_pkg::val_t                    t_reg;
    oei_pkg::val_t                    ts_reg;
    oei_pkg::val_t                    ys_reg;
    oei_pkg::val_t                    phi_reg;
    oei_pkg::val_t                    k_reg [4];
    logic signed [oei_pkg::ACC_W-1:0] acc_reg;
    logic [1:0]                       stage_reg;
    logic                             term_reg;
    logic [1:0]                       avg_reg;
    logic [oei_pkg::CNT_W-1:0]        cnt_reg;
    logic                             ovf_reg;
    logic                             out_valid_reg;
    oei_pkg::val_t                    y_out_reg;
    oei_pkg::val_t                    t_out_reg;
    logic                             sat_out_reg;

    logic [oei_pkg::METH_W-1:0]       meth;
    logic [1:0]                       last_stage;
    logic                             next_full;
    logic                             t_full;
    logic [1:0]                       t_src;
    wt_t                              t_w;
    logic                             t_last;
    logic [1:0]                       kaddr;
    oei_pkg::val_t                    k_rd;
    oei_pkg::val_t                    h_val;
    oei_pkg::val_t                    hh_val;
    logic                             avg_on;
    logic [1:0]                       avg_sh;
    logic signed [oei_pkg::ACC_W-1:0] avg_term;
    logic signed [oei_pkg::ACC_W-1:0] m_ext;
    logic signed [oei_pkg::ACC_W-1:0] acc_add;
    oei_pkg::sat_t                    ts_next;
    oei_pkg::sat_t                    ys_next;
    oei_pkg::sat_t                    y_upd;
    oei_pkg::sat_t                    t_upd;
    logic [oei_pkg::CNT_W-1:0]        cnt_init;
    logic                             mul_load;
    oei_pkg::val_t                    mul_a;
    oei_pkg::val_t                    mul_b;
    oei_pkg::sat_t                    prod_q;
    oei_pkg::sat_t                    slope_q;
    logic                             div_done;
    oei_pkg::val_t                    div_quo;

    always_comb
    begin
        meth   = (method_reg > oei_pkg::METH_RK4) ? oei_pkg::METH_RK4 : method_reg;
        h_val  = {1'b0, step_reg};
        hh_val = {2'b00, step_reg[oei_pkg::H_W-1:1]};

        unique case (meth) inside
            oei_pkg::METH_EULER:                   last_stage = 2'd0;
            oei_pkg::METH_HEUN, oei_pkg::METH_MID: last_stage = 2'd1;
            oei_pkg::METH_RK3:                     last_stage = 2'd2;
            default:                               last_stage = 2'd3;
        endcase

        // Stage that follows the current one uses the full step at its time point.
        next_full = (meth == oei_pkg::METH_HEUN)
                 || (meth == oei_pkg::METH_RK3 && stage_reg == 2'd1)
                 || (meth == oei_pkg::METH_RK4 && stage_reg == 2'd2);

        t_full = 1'b0;
        t_src  = 2'd0;
        t_w    = W_ADD;
        t_last = 1'b1;
        unique case (meth)
            oei_pkg::METH_HEUN:
            begin
                t_full = 1'b1;
            end
            oei_pkg::METH_RK3:
            begin
                if (stage_reg == 2'd2)
                begin
                    t_full = 1'b1;
                    t_src  = term_reg ? 2'd1 : 2'd0;
                    t_w    = term_reg ? W_DBL : W_SUB;
                    t_last = term_reg;
                end
            end
            oei_pkg::METH_RK4:
            begin
                t_full = (stage_reg == 2'd3);
                t_src  = stage_reg - 2'd1;
            end
            default:
            begin
                t_full = 1'b0;
            end
        endcase

        kaddr = (state_reg == S_AVG) ? avg_reg : t_src;
        k_rd  = k_reg[kaddr];

        avg_on = 1'b0;
        avg_sh = 2'd0;
        unique case (meth)
            oei_pkg::METH_HEUN:
            begin
                avg_on = (avg_reg == 2'd0) || (avg_reg == 2'd1);
            end
            oei_pkg::METH_RK3:
            begin
                avg_on = (avg_reg != 2'd3);
                avg_sh = (avg_reg == 2'd1) ? 2'd2 : 2'd0;
            end
            oei_pkg::METH_RK4:
            begin
                avg_on = 1'b1;
                avg_sh = ((avg_reg == 2'd1) || (avg_reg == 2'd2)) ? 2'd1 : 2'd0;
            end
            default:
            begin
                avg_on = 1'b0;
            end
        endcase
        avg_term = avg_on ? (oei_pkg::ACC_W'(k_rd) <<< avg_sh) : '0;

        m_ext = oei_pkg::ACC_W'(prod_q.val);
        case (t_w)
            W_SUB:   acc_add = acc_reg - m_ext;
            W_DBL:   acc_add = acc_reg + (m_ext <<< 1);
            default: acc_add = acc_reg + m_ext;
        endcase

        ts_next = oei_pkg::sat_wide(oei_pkg::WIDE_W'(t_reg)
                  + oei_pkg::WIDE_W'(next_full ? h_val : hh_val));
        ys_next = oei_pkg::sat_wide(oei_pkg::WIDE_W'(y_reg) + oei_pkg::WIDE_W'(acc_reg));
        y_upd   = oei_pkg::sat_wide(oei_pkg::WIDE_W'(y_reg) + oei_pkg::WIDE_W'(prod_q.val));
        t_upd   = oei_pkg::sat_wide(oei_pkg::WIDE_W'(t_reg) + oei_pkg::WIDE_W'(h_val));

        cnt_init = (step_count > oei_pkg::CNT_W'(oei_pkg::MAX_STEPS))
                   ? oei_pkg::CNT_W'(oei_pkg::MAX_STEPS) : step_count;

        mul_load = (state_reg == S_KMUL) || (state_reg == S_AMUL) || (state_reg == S_UMUL);
        case (state_reg)
            S_KMUL:
            begin
                mul_a = ts_reg;
                mul_b = ys_reg;
            end
            S_AMUL:
            begin
                mul_a = t_full ? h_val : hh_val;
                mul_b = k_rd;
            end
            default:
            begin
                mul_a = h_val;
                mul_b = phi_reg;
            end
        endcase

        in_ready  = (state_reg == S_IDLE);
        out_valid = out_valid_reg;
        y_final   = y_out_reg;
        t_final   = t_out_reg;
        saturated = sat_out_reg;
    end

    oei_mul u_mul (
        .clk     (clk),
        .load    (mul_load),
        .a       (mul_a),
        .b       (mul_b),
        .prod_q  (prod_q),
        .slope_q (slope_q)
    );

    oei_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DVGO),
        .num   (acc_reg),
        .div6  (meth != oei_pkg::METH_HEUN),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_KWR)
        begin
            k_reg[stage_reg] <= slope_q.val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            method_reg    <= oei_pkg::METHOD_RST;
            step_reg      <= oei_pkg::STEP_RST;
            y_reg         <= '0;
            t_reg         <= '0;
            ts_reg        <= '0;
            ys_reg        <= '0;
            phi_reg       <= '0;
            acc_reg       <= '0;
            stage_reg     <= '0;
            term_reg      <= 1'b0;
            avg_reg       <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            y_out_reg     <= '0;
            t_out_reg     <= '0;
            sat_out_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    oei_pkg::REG_METHOD: method_reg <= cfg_data[oei_pkg::METH_W-1:0];
                    oei_pkg::REG_STEP:   step_reg   <= cfg_data;
                    default:             ;
                endcase
            end

            // In the finish state the output register is handled below.
            if (out_ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        y_reg     <= y_start;
                        t_reg     <= t_start;
                        ts_reg    <= t_start;
                        ys_reg    <= y_start;
                        cnt_reg   <= cnt_init;
                        ovf_reg   <= 1'b0;
                        stage_reg <= 2'd0;
                        state_reg <= (cnt_init == '0) ? S_FIN : S_KMUL;
                    end
                end
                S_KMUL:
                begin
                    state_reg <= S_KWR;
                end
                S_KWR:
                begin
                    if (stage_reg != last_stage)
                    begin
                        ts_reg    <= ts_next.val;
                        ovf_reg   <= ovf_reg | slope_q.ovf | ts_next.ovf;
                        acc_reg   <= '0;
                        term_reg  <= 1'b0;
                        stage_reg <= stage_reg + 2'd1;
                        state_reg <= S_AMUL;
                    end
                    else if (meth == oei_pkg::METH_EULER || meth == oei_pkg::METH_MID)
                    begin
                        ovf_reg   <= ovf_reg | slope_q.ovf;
                        phi_reg   <= slope_q.val;
                        state_reg <= S_UMUL;
                    end
                    else
                    begin
                        ovf_reg   <= ovf_reg | slope_q.ovf;
                        acc_reg   <= '0;
                        avg_reg   <= 2'd0;
                        state_reg <= S_AVG;
                    end
                end
                S_AMUL:
                begin
                    state_reg <= S_AACC;
                end
                S_AACC:
                begin
                    acc_reg <= acc_add;
                    ovf_reg <= ovf_reg | prod_q.ovf;
                    if (t_last)
                    begin
                        state_reg <= S_YARG;
                    end
                    else
                    begin
                        term_reg  <= 1'b1;
                        state_reg <= S_AMUL;
                    end
                end
                S_YARG:
                begin
                    ys_reg    <= ys_next.val;
                    ovf_reg   <= ovf_reg | ys_next.ovf;
                    state_reg <= S_KMUL;
                end
                S_AVG:
                begin
                    acc_reg <= acc_reg + avg_term;
                    avg_reg <= avg_reg + 2'd1;
                    if (avg_reg == 2'd3)
                    begin
                        state_reg <= S_DVGO;
                    end
                end
                S_DVGO:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        phi_reg   <= div_quo;
                        state_reg <= S_UMUL;
                    end
                end
                S_UMUL:
                begin
                    state_reg <= S_UWR;
                end
                S_UWR:
                begin
                    y_reg     <= y_upd.val;
                    t_reg     <= t_upd.val;
                    ts_reg    <= t_upd.val;
                    ys_reg    <= y_upd.val;
                    ovf_reg   <= ovf_reg | prod_q.ovf | y_upd.ovf | t_upd.ovf;
                    cnt_reg   <= cnt_reg - 1'b1;
                    stage_reg <= 2'd0;
                    state_reg <= (cnt_reg == oei_pkg::CNT_W'(1)) ? S_FIN : S_KMUL;
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        y_out_reg     <= y_reg;
                        t_out_reg     <= t_reg;
                        sat_out_reg   <= ovf_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/oei_mul.sv]
// Shared signed multiplier with a product register, rounding and saturation.
// Depends on oei_pkg.
`default_nettype none

module oei_mul (
    input  wire logic         clk,
    input  wire logic         load,
    input  wire oei_pkg::val_t a,
    input  wire oei_pkg::val_t b,
    output oei_pkg::sat_t     prod_q,
    output oei_pkg::sat_t     slope_q
);

    logic signed [2*oei_pkg::VALUE_W-1:0] p_reg;
    logic signed [2*oei_pkg::VALUE_W:0]   ps;
    logic signed [oei_pkg::WIDE_W-1:0]    r_ext;
    logic signed [oei_pkg::WIDE_W-1:0]    r_neg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p_reg <= a * b;
        end
    end

    // Round half up, then an arithmetic shift gives the floor.
    always_comb
    begin
        ps = {p_reg[2*oei_pkg::VALUE_W-1], p_reg}
             + {{(2*oei_pkg::VALUE_W+1-oei_pkg::FRAC_W){1'b0}}, 1'b1,
                {(oei_pkg::FRAC_W-1){1'b0}}};
        r_ext = {ps[2*oei_pkg::VALUE_W], ps[2*oei_pkg::VALUE_W:oei_pkg::FRAC_W]};
        r_neg = -r_ext;
        prod_q  = oei_pkg::sat_wide(r_ext);
        slope_q = oei_pkg::sat_wide(r_neg);
    end

endmodule

`default_nettype wire

[rtl/core/oei_div.sv]
// Divider by two or six, rounding to nearest, ties away from zero, by a shift or a
// split reciprocal multiply, each step registered. Depends on oei_pkg.
`default_nettype none

module oei_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [oei_pkg::ACC_W-1:0]  num,
    input  wire logic                              div6,
    output logic                                   done,
    output oei_pkg::val_t                          quo
);

    logic                             prod_busy_reg;
    logic                             sum_busy_reg;
    logic                             done_reg;
    logic [oei_pkg::MAG_W-1:0]        m_reg;
    logic                             neg_reg;
    logic                             div6_reg;
    logic [oei_pkg::PLO_W-1:0]        plo_reg;
    logic [oei_pkg::PHI_W-1:0]        phi_reg;
    oei_pkg::val_t                    quo_reg;

    logic signed [oei_pkg::ACC_W-1:0] mag;
    logic [oei_pkg::PSUM_W-1:0]       psum;
    logic [oei_pkg::VALUE_W-1:0]      q_mag;

    always_comb
    begin
        mag = num[oei_pkg::ACC_W-1] ? -num : num;
        mag = mag + (div6 ? oei_pkg::ACC_W'(3) : oei_pkg::ACC_W'(1));
        psum  = {phi_reg, {oei_pkg::DIV_LO_W{1'b0}}} + oei_pkg::PSUM_W'(plo_reg);
        q_mag = div6_reg ? psum[oei_pkg::RCP6_SH +: oei_pkg::VALUE_W]
                         : m_reg[oei_pkg::VALUE_W:1];
        quo   = quo_reg;
        done  = done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_busy_reg <= 1'b0;
            sum_busy_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            prod_busy_reg <= start;
            sum_busy_reg  <= prod_busy_reg;
            done_reg      <= sum_busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            m_reg    <= mag[oei_pkg::MAG_W-1:0];
            neg_reg  <= num[oei_pkg::ACC_W-1];
            div6_reg <= div6;
        end
        if (prod_busy_reg)
        begin
            plo_reg <= oei_pkg::PLO_W'(m_reg[oei_pkg::DIV_LO_W-1:0])
                       * oei_pkg::PLO_W'(oei_pkg::RCP6);
            phi_reg <= oei_pkg::PHI_W'(m_reg[oei_pkg::MAG_W-1:oei_pkg::DIV_LO_W])
                       * oei_pkg::PHI_W'(oei_pkg::RCP6);
        end
        if (sum_busy_reg)
        begin
            quo_reg <= neg_reg ? -q_mag : q_mag;
        end
    end

endmodule

`default_nettype wire

[rtl/core/oei_check.sv]
// Port-level checks for ode_explicit_integrator, bound to the top level.
// Depends on oei_pkg and the top-level port list.
`default_nettype none

module oei_check (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              cfg_write,
    input wire logic [oei_pkg::CFG_IDX_W-1:0]     cfg_index,
    input wire logic [oei_pkg::CFG_DATA_W-1:0]    cfg_data,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire oei_pkg::val_t                     y_start,
    input wire oei_pkg::val_t                     t_start,
    input wire logic [oei_pkg::CNT_W-1:0]         step_count,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire oei_pkg::val_t                     y_final,
    input wire oei_pkg::val_t                     t_final,
    input wire logic                              saturated
);

    // A word that is not taken holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(y_final)
                                    && $stable(t_final) && $stable(saturated))
        else $error("output word changed while stalled");

    // The block is busy right after it takes a word.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after accept");

    // A zero-step word passes through the finish state and comes back unchanged.
    a_zero_steps: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && step_count == '0 && !out_valid
        |=> ##1 out_valid && y_final == $past(y_start, 2)
                && t_final == $past(t_start, 2) && !saturated)
        else $error("zero-step word not passed through");

    // A new result always leaves the sequencer idle.
    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("not idle after producing a result");

endmodule

bind ode_explicit_integrator oei_check u_oei_check (.*);

`default_nettype wire
